[design/ptcc_pkg.sv]
// ptcc_pkg: shared types, widths and codes for the pwm timer compare channels block
// no dependencies; used by ptcc_if, ptcc_cnt, ptcc_chan and the top level

package ptcc_pkg;

	localparam int CNT_W        = 16;
	localparam int CHAN_SLOTS   = 4;
	localparam int NUM_CHANNELS = 4;
	localparam int ACT_W        = 3;
	localparam int SET_W        = CNT_W + ACT_W;
	localparam int MODE_W       = 3;
	localparam int CFG_IDX_W    = 3;

	// request codes carried by an input word
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_CLR   = 2'd3
	} req_t;

	// count mode codes, remaining codes never count
	localparam logic [MODE_W-1:0] CM_ALWAYS = 3'd0;
	localparam logic [MODE_W-1:0] CM_LOW    = 3'd1;
	localparam logic [MODE_W-1:0] CM_HIGH   = 3'd2;

	// channel action codes
	localparam logic [ACT_W-1:0] ACT_SET     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TGL_RST = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET_RST = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TGL     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RST     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TGL_SET = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RST_SET = 3'd6;
	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN3 = 3'd7;

	// what the counter tells every channel on one tick
	typedef struct packed {
		logic             upd;
		logic [CNT_W-1:0] cnt;
		logic             period_end;
		logic             saw;
	} chan_evt_t;

endpackage

[design/ptcc_if.sv]
// ptcc_if: valid/ready channel interfaces for input and result words
// depends on ptcc_pkg

interface ptcc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       ext_in;

	modport source (output valid, output req_type, output ext_in, input ready);
	modport sink   (input valid, input req_type, input ext_in, output ready);
endinterface

interface ptcc_out_if;
	logic                      valid;
	logic                      ready;
	logic [ptcc_pkg::CNT_W-1:0]      count_value;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] event_levels;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] rise_mask;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] fall_mask;
	logic                      period_end;
	logic                      did_count;

	modport source (output valid, output count_value, output event_levels, output rise_mask,
		output fall_mask, output period_end, output did_count, input ready);
	modport sink   (input valid, input count_value, input event_levels, input rise_mask,
		input fall_mask, input period_end, input did_count, output ready);
endinterface

[design/ptcc_cnt.sv]
// ptcc_cnt: run flag, counter and direction registers with the tick decode
// depends on ptcc_pkg

module ptcc_cnt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [1:0]                   req_type,
	input  logic                         ext_in,
	input  logic [ptcc_pkg::MODE_W-1:0]  count_mode,
	input  logic                         sawtooth_mode,
	input  logic [ptcc_pkg::CNT_W-1:0]   low_threshold,
	input  logic [ptcc_pkg::CNT_W-1:0]   high_threshold,
	output ptcc_pkg::chan_evt_t          evt,
	output logic [ptcc_pkg::CNT_W-1:0]   cnt_nxt,
	output logic [ptcc_pkg::CNT_W-1:0]   cnt
);

	logic                       running_q;
	logic                       down_q;
	logic [ptcc_pkg::CNT_W-1:0] cnt_q;
	logic                       mode_ok;
	logic                       tick;
	logic [ptcc_pkg::CNT_W-1:0] stepped;
	logic                       at_end;
	logic                       down_nxt;
	logic                       running_nxt;

	always_comb begin
		case (count_mode)
			ptcc_pkg::CM_ALWAYS: mode_ok = 1'b1;
			ptcc_pkg::CM_LOW:    mode_ok = ~ext_in;
			ptcc_pkg::CM_HIGH:   mode_ok = ext_in;
			default:             mode_ok = 1'b0;
		endcase
	end

	assign tick    = (ptcc_pkg::req_t'(req_type) == ptcc_pkg::REQ_TICK) && running_q && mode_ok;
	assign stepped = down_q ? cnt_q - ptcc_pkg::CNT_W'(1) : cnt_q + ptcc_pkg::CNT_W'(1);
	// down end sits one below the low threshold
	assign at_end  = down_q ? (stepped == low_threshold - ptcc_pkg::CNT_W'(1))
		: (stepped == high_threshold);

	always_comb begin
		cnt_nxt     = cnt_q;
		down_nxt    = down_q;
		running_nxt = running_q;
		unique case (ptcc_pkg::req_t'(req_type))
			ptcc_pkg::REQ_START: running_nxt = 1'b1;
			ptcc_pkg::REQ_STOP:  running_nxt = 1'b0;
			ptcc_pkg::REQ_CLR: begin
				cnt_nxt  = low_threshold;
				down_nxt = 1'b0;
			end
			ptcc_pkg::REQ_TICK: begin
				if (tick) begin
					cnt_nxt = (at_end && sawtooth_mode) ? low_threshold : stepped;
					if (at_end && !sawtooth_mode)
						down_nxt = ~down_q;
				end
			end
		endcase
	end

	assign evt.upd        = fire && tick;
	assign evt.cnt        = stepped;
	assign evt.period_end = at_end;
	assign evt.saw        = sawtooth_mode;
	assign cnt            = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			down_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (fire) begin
			running_q <= running_nxt;
			down_q    <= down_nxt;
			cnt_q     <= cnt_nxt;
		end
	end

endmodule

[design/ptcc_chan.sv]
// ptcc_chan: one compare channel, level and second-match registers plus action logic
// depends on ptcc_pkg

module ptcc_chan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ptcc_pkg::SET_W-1:0]  setting,
	input  ptcc_pkg::chan_evt_t         evt,
	output logic                        level,
	output logic                        level_nxt
);

	logic                       level_q;
	logic                       sm_q;
	logic                       sm_nxt;
	logic [ptcc_pkg::ACT_W-1:0] act;
	logic                       match;
	logic                       first;
	logic                       second;

	assign act   = setting[ptcc_pkg::SET_W-1:ptcc_pkg::CNT_W];
	assign match = setting[ptcc_pkg::CNT_W-1:0] == evt.cnt;

	// two-step actions: first step on a match, second on end or on alternate match
	assign first  = ((act == ptcc_pkg::ACT_TGL_RST) || (act == ptcc_pkg::ACT_TGL_SET)) ? ~level_q
		: (act == ptcc_pkg::ACT_SET_RST);
	assign second = !((act == ptcc_pkg::ACT_TGL_RST) || (act == ptcc_pkg::ACT_SET_RST));

	always_comb begin
		level_nxt = level_q;
		sm_nxt    = sm_q;
		case (act)
			ptcc_pkg::ACT_SET: if (match) level_nxt = 1'b1;
			ptcc_pkg::ACT_TGL: if (match) level_nxt = ~level_q;
			ptcc_pkg::ACT_RST: if (match) level_nxt = 1'b0;
			ptcc_pkg::ACT_NONE: sm_nxt = 1'b0;
			default: begin
				if (evt.saw) begin
					if (match)
						level_nxt = first;
					else if (evt.period_end)
						level_nxt = second;
				end else if (match) begin
					level_nxt = sm_q ? second : first;
					sm_nxt    = ~sm_q;
				end
			end
		endcase
	end

	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			sm_q    <= 1'b0;
		end else if (evt.upd) begin
			level_q <= level_nxt;
			sm_q    <= sm_nxt;
		end
	end

endmodule

[design/pwm_timer_compare_channels_core.sv]
// pwm_timer_compare_channels_core: top level, config registers, channels and result register
// depends on ptcc_pkg, ptcc_if, ptcc_cnt, ptcc_chan

// One 16-bit pwm timer slice with four compare channels. Each input word is a tick, start,
// stop or counter-reset request; every word yields exactly one result word carrying the
// counter, the channel levels, their rise/fall masks, the period end flag and whether the
// tick counted. A word is taken whenever the output register is empty or being drained; the counter
// and channel state update at acceptance and the result lands in a single output register in the
// next cycle; the sustained rate is one word per clock while the sink takes results. The only thing that
// holds the input back is a full output register that the sink is not taking. Configuration
// is a plain write port (enable, index, 19-bit data) and is meant to be written while idle.

module pwm_timer_compare_channels_core (
	input  logic                            clk,
	input  logic                            arst_n,
	ptcc_in_if.sink                         item_in,
	ptcc_out_if.source                      result_out,
	input  logic                            cfg_we,
	input  logic [ptcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptcc_pkg::SET_W-1:0]      cfg_data
);

	// configuration registers
	logic [ptcc_pkg::MODE_W-1:0] mode_q;
	logic                        saw_q;
	logic [ptcc_pkg::CNT_W-1:0]  low_q;
	logic [ptcc_pkg::CNT_W-1:0]  high_q;
	logic [ptcc_pkg::SET_W-1:0]  chan_set_q [ptcc_pkg::CHAN_SLOTS];

	// handshake and datapath
	logic                            fire;
	logic                            out_valid_q;
	ptcc_pkg::chan_evt_t             evt;
	logic [ptcc_pkg::CNT_W-1:0]      cnt_nxt;
	logic [ptcc_pkg::CNT_W-1:0]      cnt_cur;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] lvl_cur;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] lvl_nxt;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] lvl_new;

	// result register
	logic [ptcc_pkg::CNT_W-1:0]      cnt_out_q;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] lvl_out_q;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] rise_q;
	logic [ptcc_pkg::CHAN_SLOTS-1:0] fall_q;
	logic                            pend_q;
	logic                            did_q;

	// register writes, every index of the 3-bit space names a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			saw_q      <= 1'b0;
			low_q      <= '0;
			high_q     <= '0;
			chan_set_q <= '{default: '0};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ptcc_pkg::CFG_MODE:  mode_q        <= cfg_data[ptcc_pkg::MODE_W-1:0];
				ptcc_pkg::CFG_SAW:   saw_q         <= cfg_data[0];
				ptcc_pkg::CFG_LOW:   low_q         <= cfg_data[ptcc_pkg::CNT_W-1:0];
				ptcc_pkg::CFG_HIGH:  high_q        <= cfg_data[ptcc_pkg::CNT_W-1:0];
				ptcc_pkg::CFG_CHAN0: chan_set_q[0] <= cfg_data;
				ptcc_pkg::CFG_CHAN1: chan_set_q[1] <= cfg_data;
				ptcc_pkg::CFG_CHAN2: chan_set_q[2] <= cfg_data;
				ptcc_pkg::CFG_CHAN3: chan_set_q[3] <= cfg_data;
			endcase
		end
	end

	// take a new word whenever the result register is empty or being drained
	assign item_in.ready = !out_valid_q || result_out.ready;
	assign fire          = item_in.valid && item_in.ready;

	// counter, direction and run flag
	ptcc_cnt u_cnt (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.req_type       (item_in.req_type),
		.ext_in         (item_in.ext_in),
		.count_mode     (mode_q),
		.sawtooth_mode  (saw_q),
		.low_threshold  (low_q),
		.high_threshold (high_q),
		.evt            (evt),
		.cnt_nxt        (cnt_nxt),
		.cnt            (cnt_cur)
	);

	// compare channels, unused slots read as a steady low level
	for (genvar i = 0; i < ptcc_pkg::CHAN_SLOTS; i++) begin : g_chan
		if (i < ptcc_pkg::NUM_CHANNELS) begin : g_used
			ptcc_chan u_chan (
				.clk       (clk),
				.arst_n    (arst_n),
				.setting   (chan_set_q[i]),
				.evt       (evt),
				.level     (lvl_cur[i]),
				.level_nxt (lvl_nxt[i])
			);
		end else begin : g_unused
			assign lvl_cur[i] = 1'b0;
			assign lvl_nxt[i] = 1'b0;
		end
	end

	// levels only move on a tick that counted
	assign lvl_new = evt.upd ? lvl_nxt : lvl_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with the word that was just accepted
	always_ff @(posedge clk) begin
		if (fire) begin
			cnt_out_q <= cnt_nxt;
			lvl_out_q <= lvl_new;
			rise_q    <= lvl_new & ~lvl_cur;
			fall_q    <= lvl_cur & ~lvl_new;
			pend_q    <= evt.upd && evt.period_end;
			did_q     <= evt.upd;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.count_value  = cnt_out_q;
	assign result_out.event_levels = lvl_out_q;
	assign result_out.rise_mask    = rise_q;
	assign result_out.fall_mask    = fall_q;
	assign result_out.period_end   = pend_q;
	assign result_out.did_count    = did_q;

`ifndef SYNTH
	// a level cannot rise and fall on the same word
	a_rise_fall_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.rise_mask & result_out.fall_mask) == '0)
		else $error("rise and fall masks overlap");

	// edges and period end only come from a tick that counted
	a_no_count_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.did_count) |->
		(result_out.rise_mask == '0 && result_out.fall_mask == '0 && !result_out.period_end))
		else $error("event flags on a word that did not count");

	// reported counter tracks the live counter register
	a_count_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> result_out.count_value == cnt_cur)
		else $error("result counter differs from counter state");

	// a counter reset word reports the low threshold
	a_clear_loads_low: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_in.req_type == ptcc_pkg::REQ_CLR) |=> cnt_cur == low_q)
		else $error("counter reset did not load low threshold");
`endif

endmodule

[tb/sv/pwm_timer_compare_channels_core_tb.sv]
// pwm_timer_compare_channels_core_tb: self-checking bench for the pwm timer with compare channels
// depends on ptcc_pkg, ptcc_if and pwm_timer_compare_channels_core; a scoreboard class predicts
// every result word from the accepted input words and the register settings

module pwm_timer_compare_channels_core_tb;
	import ptcc_pkg::*;

	// highest count mode code, one of the codes that never count
	localparam logic [MODE_W-1:0] CM_NEVER_TOP = '1;
	// random words to send after the directed part
	localparam int RANDOM_WORDS = 1325;
	// cycles the receiver holds off when asked for a long stall
	localparam int LONG_HOLD = 240;

	typedef struct packed {
		logic [CNT_W-1:0]      count_value;
		logic [CHAN_SLOTS-1:0] event_levels;
		logic [CHAN_SLOTS-1:0] rise_mask;
		logic [CHAN_SLOTS-1:0] fall_mask;
		logic                  period_end;
		logic                  did_count;
	} timer_result_t;

	// timer predictor plus the queue of result words it has promised
	class timer_scoreboard;
		logic [MODE_W-1:0]     mode;
		logic                  saw;
		logic [CNT_W-1:0]      lo_thr;
		logic [CNT_W-1:0]      hi_thr;
		logic [SET_W-1:0]      chan_cfg [CHAN_SLOTS];
		logic [CNT_W-1:0]      cnt;
		logic                  down;
		logic                  run;
		logic [CHAN_SLOTS-1:0] lvl;
		logic [CHAN_SLOTS-1:0] second_step;
		timer_result_t         expected_q [$];
		int                    failures;

		function new();
			mode = '0;
			saw = 1'b0;
			lo_thr = '0;
			hi_thr = '0;
			foreach (chan_cfg[i]) chan_cfg[i] = '0;
			cnt = '0;
			down = 1'b0;
			run = 1'b0;
			lvl = '0;
			second_step = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SET_W-1:0] data);
			case (idx)
				CFG_MODE: mode = data[MODE_W-1:0];
				CFG_SAW:  saw = data[0];
				CFG_LOW:  lo_thr = data[CNT_W-1:0];
				CFG_HIGH: hi_thr = data[CNT_W-1:0];
				default:  chan_cfg[idx - CFG_CHAN0] = data;
			endcase
		endfunction

		function bit tick_counts(logic ext);
			case (mode)
				CM_ALWAYS: return 1'b1;
				CM_LOW:    return !ext;
				CM_HIGH:   return ext;
				default:   return 1'b0;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// new level of one channel; two-step actions also walk second_step
		function logic next_level(int ch, logic cur, bit hit, bit at_end);
			logic [ACT_W-1:0] act;
			logic first_val;
			logic second_val;
			act = chan_cfg[ch][SET_W-1:CNT_W];
			case (act)
				ACT_SET:  return hit ? 1'b1 : cur;
				ACT_TGL:  return hit ? ~cur : cur;
				ACT_RST:  return hit ? 1'b0 : cur;
				ACT_NONE: begin
					second_step[ch] = 1'b0;
					return cur;
				end
				default: ;
			endcase
			first_val = (act == ACT_TGL_RST || act == ACT_TGL_SET) ? ~cur : (act == ACT_SET_RST);
			second_val = (act == ACT_TGL_SET || act == ACT_RST_SET);
			if (saw)
				return hit ? first_val : (at_end ? second_val : cur);
			if (!hit)
				return cur;
			if (!second_step[ch]) begin
				second_step[ch] = 1'b1;
				return first_val;
			end
			second_step[ch] = 1'b0;
			return second_val;
		endfunction

		function void note_word(req_t req, logic ext);
			timer_result_t r;
			logic [CHAN_SLOTS-1:0] prev;
			logic [CHAN_SLOTS-1:0] nxt;
			bit at_end;
			r = '0;
			prev = lvl;
			nxt = '0;
			case (req)
				REQ_START: run = 1'b1;
				REQ_STOP:  run = 1'b0;
				REQ_CLR: begin
					cnt = lo_thr;
					down = 1'b0;
				end
				default: if (run && tick_counts(ext)) begin
					r.did_count = 1'b1;
					if (down) begin
						cnt = cnt - 1'b1;
						at_end = (cnt == lo_thr - 1'b1);
					end else begin
						cnt = cnt + 1'b1;
						at_end = (cnt == hi_thr);
					end
					if (at_end && !saw)
						down = ~down;
					for (int ch = 0; ch < NUM_CHANNELS; ch++)
						nxt[ch] = next_level(ch, lvl[ch], chan_cfg[ch][CNT_W-1:0] == cnt, at_end);
					lvl = nxt;
					if (at_end && saw)
						cnt = lo_thr;
					r.period_end = at_end;
					r.rise_mask = lvl & ~prev;
					r.fall_mask = prev & ~lvl;
				end
			endcase
			r.count_value = cnt;
			r.event_levels = lvl;
			expected_q.push_back(r);
		endfunction

		function void match_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (expected_q.size() == 0) begin
				$error("result word arrived with no expected word pending");
				failures++;
				return;
			end
			want = expected_q.pop_front();
			match_field("count_value", want.count_value, got.count_value);
			match_field("event_levels", CNT_W'(want.event_levels), CNT_W'(got.event_levels));
			match_field("rise_mask", CNT_W'(want.rise_mask), CNT_W'(got.rise_mask));
			match_field("fall_mask", CNT_W'(want.fall_mask), CNT_W'(got.fall_mask));
			match_field("period_end", CNT_W'(want.period_end), CNT_W'(got.period_end));
			match_field("did_count", CNT_W'(want.did_count), CNT_W'(got.did_count));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SET_W-1:0]     cfg_data;

	ptcc_in_if  in_ch ();
	ptcc_out_if out_ch ();

	timer_scoreboard sb = new();

	// words sent in the random part
	int items_done = 0;
	// bumped by the stimulus to ask the receiver for one long stall
	int hold_requests = 0;

	pwm_timer_compare_channels_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_ch),
		.result_out (out_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// both handshakes sampled at the rising edge; the input side is noted first so a
	// same-edge result can never outrun its own prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_word(req_t'(in_ch.req_type), in_ch.ext_in);
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.count_value, out_ch.event_levels, out_ch.rise_mask,
					out_ch.fall_mask, out_ch.period_end, out_ch.did_count});
		end
	end

	// receiver: switches between random stall patterns, and on request
	// holds ready low for a long stretch so the output register fills and input stalls
	initial begin
		int pattern;
		int pattern_left;
		int beat;
		int hold_left;
		int hold_served;
		pattern = 0;
		pattern_left = 0;
		beat = 0;
		hold_left = 0;
		hold_served = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (pattern_left == 0) begin
				pattern = $urandom_range(0, 3);
				pattern_left = $urandom_range(20, 80);
			end
			pattern_left--;
			beat++;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (pattern)
					0:       out_ch.ready <= 1'b1;
					1:       out_ch.ready <= 1'($urandom_range(0, 1));
					2:       out_ch.ready <= (beat % 3 == 0);
					default: out_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// offer one word from a falling edge and hold it until the block takes it
	task automatic send_word(req_t r, logic e);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= r;
		in_ch.ext_in <= e;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// stop offering, wait for every promised word, then leave a margin for latency
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SET_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [MODE_W-1:0] mode, logic saw, logic [CNT_W-1:0] lo,
		logic [CNT_W-1:0] hi, logic [SET_W-1:0] c0, logic [SET_W-1:0] c1,
		logic [SET_W-1:0] c2, logic [SET_W-1:0] c3);
		write_reg(CFG_MODE, SET_W'(mode));
		write_reg(CFG_SAW, SET_W'(saw));
		write_reg(CFG_LOW, SET_W'(lo));
		write_reg(CFG_HIGH, SET_W'(hi));
		write_reg(CFG_CHAN0, c0);
		write_reg(CFG_CHAN1, c1);
		write_reg(CFG_CHAN2, c2);
		write_reg(CFG_CHAN3, c3);
	endtask

	// mostly ticks while running; a stopped timer is restarted soon so ticks keep counting
	task automatic pick_word(output req_t r, output logic e);
		int roll;
		e = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (!sb.run && roll < 25)
			r = REQ_START;
		else if (roll < 90)
			r = REQ_TICK;
		else if (roll < 94)
			r = REQ_CLR;
		else if (roll < 97)
			r = REQ_STOP;
		else
			r = REQ_START;
	endtask

	// bursts of random length, with random gaps between them when gaps are on
	task automatic run_items(int n, bit gaps);
		int burst;
		req_t r;
		logic e;
		burst = 0;
		repeat (n) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				if (gaps && $urandom_range(0, 3) != 0)
					pause($urandom_range(1, 6));
			end
			burst--;
			// sb state is current here: the previous word was taken at the last edge
			pick_word(r, e);
			items_done++;
			send_word(r, e);
		end
	endtask

	initial begin
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		logic [CNT_W-1:0] span;
		logic [CNT_W-1:0] cmp;
		logic [MODE_W-1:0] mode;
		logic saw;
		logic [SET_W-1:0] chan [CHAN_SLOTS];
		int phase;
		int roll;
		int n;
		bit hold_phase;

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.req_type <= REQ_TICK;
		in_ch.ext_in <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_MODE;
		cfg_data <= '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: tick while stopped, start, counting, stop, ignored tick, counter reset
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_START, 1'b0);
		send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_STOP, 1'b1);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_CLR, 1'b0);
		send_word(REQ_START, 1'b0);
		drain();

		// count on low input, reversing at 3 and at 0xffff: top turn, a rejected tick,
		// bottom turn at 0xffff, first half of the actions
		configure(CM_LOW, 1'b0, 16'd0, 16'd3, {ACT_SET, 16'd2}, {ACT_TGL_RST, 16'd1},
			{ACT_SET_RST, 16'd3}, {ACT_TGL, 16'd0});
		send_word(REQ_CLR, 1'b1);
		repeat (6) send_word(REQ_TICK, 1'b0);
		send_word(REQ_TICK, 1'b1);
		repeat (2) send_word(REQ_TICK, 1'b0);
		drain();

		// count on high input, sawtooth with the low threshold above the high one so the
		// counter wraps through zero, second half of the actions
		configure(CM_HIGH, 1'b1, 16'hFFFE, 16'd1, {ACT_RST, 16'hFFFF}, {ACT_TGL_SET, 16'd0},
			{ACT_RST_SET, 16'd1}, {ACT_NONE, 16'hFFFF});
		send_word(REQ_CLR, 1'b0);
		repeat (5) send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);

		// random phases: fresh settings each time, a few early phases forced to extremes
		phase = 0;
		while (items_done < RANDOM_WORDS) begin
			drain();
			span = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 4))
				: CNT_W'($urandom_range(5, 40));
			roll = $urandom_range(0, 9);
			if (phase == 0)
				mode = CM_NEVER_TOP;
			else if (roll < 6)
				mode = CM_ALWAYS;
			else if (roll < 8)
				mode = CM_LOW;
			else if (roll < 9)
				mode = CM_HIGH;
			else
				mode = MODE_W'($urandom_range(CM_HIGH + 1, CM_NEVER_TOP));
			saw = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
			case (phase)
				1: begin
					lo = 16'hFFFA;
					hi = 16'hFFFF;
				end
				2: begin
					lo = '0;
					hi = span;
				end
				4: begin
					lo = 16'hFFFF;
					hi = span;
				end
				5: begin
					hi = '0;
					lo = hi - span;
				end
				default: begin
					lo = CNT_W'($urandom);
					hi = lo + span;
				end
			endcase
			for (int ch = 0; ch < CHAN_SLOTS; ch++) begin
				roll = $urandom_range(0, 9);
				if (roll < 8)
					cmp = lo + CNT_W'($urandom_range(0, span));
				else if (roll < 9)
					cmp = hi;
				else
					cmp = CNT_W'($urandom);
				chan[ch] = {ACT_W'($urandom_range(0, 7)), cmp};
				if (phase == 0)
					chan[ch] = '1;
				else if (phase == 3)
					chan[ch] = '0;
			end
			configure(mode, saw, lo, hi, chan[0], chan[1], chan[2], chan[3]);

			// long receiver stall while the sender keeps offering back to back
			hold_phase = (phase == 3 || phase == 9);
			if (hold_phase)
				hold_requests++;

			// well-formed start of a phase; now and then the counter carries over
			if ($urandom_range(0, 5) != 0) begin
				send_word(REQ_CLR, 1'($urandom_range(0, 1)));
				items_done++;
			end
			send_word(REQ_START, 1'($urandom_range(0, 1)));
			items_done++;
			n = (mode > CM_HIGH) ? 30 : $urandom_range(40, 110);
			run_items(n, !hold_phase && $urandom_range(0, 3) != 0);
			phase++;
		end

		drain();
		repeat (8) @(negedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
